// File: hdl/tws_pkg.sv
`default_nettype none

package tws_pkg;

    // Fixed-point default and field widths
    localparam int FRAC_BITS_DEF = 16;
    localparam int TS_W          = 11;
    localparam int ROW_W         = 12;
    localparam int TEXCOL_W      = 10;
    localparam int WH_W          = 32;
    localparam int HIT_W         = 20;
    localparam int TEXEL_W       = 20;
    localparam int SEL_W         = 3;
    localparam int POS_W         = 32;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;

    // Register reset values and limits
    localparam logic [TS_W-1:0]  TEX_SIZE_RST = 11'd64;
    localparam logic [TS_W-1:0]  TEX_SIZE_MAX = 11'd1024;
    localparam logic [ROW_W-1:0] SCREEN_H_RST = 12'd720;

    // Command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // Register index (paddr word select)
    localparam logic REG_TEX_SIZE = 1'b0;
    localparam logic REG_SCREEN_H = 1'b1;

    // Wall face / texture codes
    localparam logic [SEL_W-1:0] TEX_DOOR  = 3'd0;
    localparam logic [SEL_W-1:0] TEX_EAST  = 3'd1;
    localparam logic [SEL_W-1:0] TEX_WEST  = 3'd2;
    localparam logic [SEL_W-1:0] TEX_NORTH = 3'd3;
    localparam logic [SEL_W-1:0] TEX_SOUTH = 3'd4;

    // Divider operations
    typedef enum logic [1:0] {
        DIV_HIT,
        DIV_STEP,
        DIV_COL
    } t_div_op;

    typedef struct packed {
        logic                command;
        logic [ROW_W-1:0]    column;
        logic [ROW_W-1:0]    span_start;
        logic [ROW_W-1:0]    span_end;
        logic [WH_W-1:0]     wall_height;
        logic [HIT_W-1:0]    hit_coord_h;
        logic [HIT_W-1:0]    hit_coord_v;
        logic                is_vertical;
        logic                is_door;
        logic                ray_right;
        logic                ray_left;
        logic                ray_up;
    } t_in_item;

    typedef struct packed {
        logic [ROW_W-1:0]    pixel_column;
        logic [ROW_W-1:0]    pixel_row;
        logic [SEL_W-1:0]    texture_select;
        logic [TEXEL_W-1:0]  texel_index;
        logic                last;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic    latch_start;
        logic    emit_pixel;
        logic    div_go;
        t_div_op div_op;
        logic    cap_hit;
        logic    cap_step;
        logic    step_ones;
        logic    cap_col;
        logic    clear_pos;
        logic    mul_go;
        logic    cap_pos;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_pixel;
        logic rows_left;
        logic out_free;
        logic wh_zero;
        logic pos_zero;
        logic div_done;
        logic mul_done;
        logic ts_written;
    } t_dp_status;

endpackage

`default_nettype wire

// File: hdl/tws_stream_if.sv
`default_nettype none

interface tws_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/tws_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle, MSB of the dividend first.
module tws_div import tws_pkg::*; #(
    parameter int DVD_W = TS_W + 2 * FRAC_BITS_DEF,
    parameter int DVS_W = WH_W,
    parameter int CNT_W = $clog2(DVD_W + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    input  logic [CNT_W-1:0] i_iters,
    output logic [DVD_W-1:0] o_quotient,
    output logic [DVS_W-1:0] o_remainder,
    output logic             o_done
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_dvd;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_divisor;

    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   rem_sub;
    logic             ge;
    logic [DVS_W-1:0] n_rem;

    // One shift-subtract step
    always_comb begin
        rem_sh  = {r_rem, r_dvd[DVD_W-1]};
        rem_sub = rem_sh - {1'b0, r_divisor};
        ge      = (rem_sh >= {1'b0, r_divisor});
        n_rem   = ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CNT_W'(1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Operands and partial results
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_cnt     <= i_iters;
            r_dvd     <= i_dividend;
            r_divisor <= i_divisor;
            r_rem     <= '0;
            r_quo     <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= n_rem;
            r_quo <= {r_quo[DVD_W-2:0], ge};
        end
    end

    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
    assign o_done      = r_done;

endmodule

`default_nettype wire

// File: hdl/tws_mul.sv
`default_nettype none

// Shift-add multiplier, one multiplier bit per cycle, LSB first.
module tws_mul import tws_pkg::*; #(
    parameter int A_W   = 33,
    parameter int B_W   = WH_W,
    parameter int CNT_W = $clog2(A_W + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic [A_W+B_W-1:0] o_product,
    output logic               o_done
);

    localparam int P_W = A_W + B_W;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [P_W-1:0]   r_p;
    logic [B_W-1:0]   r_b;

    logic [B_W:0]     sum;
    logic [P_W-1:0]   n_p;

    // Add the multiplicand into the upper half when the low bit is set
    always_comb begin
        sum = {1'b0, r_p[P_W-1:A_W]} + (r_p[0] ? {1'b0, r_b} : '0);
        n_p = {sum, r_p[A_W-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CNT_W'(1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_cnt <= CNT_W'(A_W);
            r_p   <= {{B_W{1'b0}}, i_a};
            r_b   <= i_b;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            r_p   <= n_p;
        end
    end

    assign o_product = r_p;
    assign o_done    = r_done;

endmodule

`default_nettype wire

// File: hdl/tws_dp.sv
`default_nettype none

module tws_dp import tws_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_in_item          i_in_data,
    output t_out_item         o_out_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status
);

    // Divider holds size << 2*FRAC_BITS
    localparam int DIV_W     = TS_W + 2 * FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);
    // Signed start offset in units of 2^-(FRAC_BITS+1)
    localparam int OFF_W     = ((FRAC_BITS + 14 > 33) ? FRAC_BITS + 14 : 33) + 1;
    localparam int MUL_A_W   = OFF_W - 1;
    localparam int PROD_W    = MUL_A_W + WH_W;
    localparam int PR_W      = PROD_W - FRAC_BITS - 1;

    // Configuration
    logic [TS_W-1:0]      r_tex_size;
    logic [ROW_W-1:0]     r_screen_h;

    // Column state
    logic [ROW_W-1:0]     r_cur_column;
    logic [SEL_W-1:0]     r_cur_texture;
    logic [TEXCOL_W-1:0]  r_tex_column;
    logic [TEXCOL_W-1:0]  r_col_mod;
    logic [POS_W-1:0]     r_step;
    logic [POS_W-1:0]     r_pos;
    logic [ROW_W-1:0]     r_cur_row;
    logic [ROW_W-1:0]     r_end_row;
    logic [WH_W-1:0]      r_wh;

    // Output stage
    t_out_item            r_out;
    logic                 r_out_valid;

    logic                 apb_wr;
    logic [TS_W-1:0]      ts_eff;
    logic [TS_W-1:0]      ts_m1;
    logic [SEL_W-1:0]     face;
    logic [HIT_W-1:0]     hit_sel;

    logic [DIV_W-1:0]     div_dividend;
    logic [WH_W-1:0]      div_divisor;
    logic [DIV_CNT_W-1:0] div_iters;
    logic [DIV_W-1:0]     div_quo;
    logic [WH_W-1:0]      div_rem;
    logic                 div_done;
    logic [DIV_W+WH_W-1:0] quo_ext;
    logic [POS_W-1:0]     step_sat;

    logic signed [ROW_W:0]   row_diff;
    logic signed [OFF_W-1:0] off2;
    logic                    off_pos;

    logic [PROD_W-1:0]    mul_prod;
    logic                 mul_done;
    logic [PR_W-1:0]      pos_raw;
    logic [PR_W-1:0]      max_pos;
    logic [PR_W-1:0]      pos_lim;
    logic [PR_W-1:0]      pos_clamp;

    logic [POS_W-1:0]     row_int;
    logic [TEXCOL_W-1:0]  row_sat;
    logic [TS_W+TEXCOL_W-1:0] texel_full;
    logic [POS_W:0]       pos_sum;
    logic [POS_W-1:0]     pos_next;
    logic [ROW_W-1:0]     row_next;

    // APB register file, always ready
    assign apb_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_size <= TEX_SIZE_RST;
            r_screen_h <= SCREEN_H_RST;
        end else if (apb_wr) begin
            case (paddr[2])
                REG_TEX_SIZE: r_tex_size <= pwdata[TS_W-1:0];
                REG_SCREEN_H: r_screen_h <= pwdata[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_TEX_SIZE: prdata = APB_DW'(r_tex_size);
            REG_SCREEN_H: prdata = APB_DW'(r_screen_h);
            default:      prdata = '0;
        endcase
    end

    // Effective texture size: zero acts as 1, clipped at 1024
    always_comb begin
        if (r_tex_size == '0) begin
            ts_eff = TS_W'(1);
        end else if (r_tex_size > TEX_SIZE_MAX) begin
            ts_eff = TEX_SIZE_MAX;
        end else begin
            ts_eff = r_tex_size;
        end
        ts_m1 = ts_eff - TS_W'(1);
    end

    // Face select, door has priority
    always_comb begin
        if (i_in_data.is_door) begin
            face = TEX_DOOR;
        end else if (i_in_data.is_vertical && i_in_data.ray_right) begin
            face = TEX_EAST;
        end else if (i_in_data.is_vertical && i_in_data.ray_left) begin
            face = TEX_WEST;
        end else if (!i_in_data.is_vertical && i_in_data.ray_up) begin
            face = TEX_NORTH;
        end else begin
            face = TEX_SOUTH;
        end
        hit_sel = i_in_data.is_vertical ? i_in_data.hit_coord_v : i_in_data.hit_coord_h;
    end

    // Divider operand select; operands are left-aligned so only live bits iterate
    always_comb begin
        case (i_cmd.div_op)
            DIV_HIT: begin
                div_dividend = {hit_sel, {(DIV_W-HIT_W){1'b0}}};
                div_divisor  = WH_W'(ts_eff);
                div_iters    = DIV_CNT_W'(HIT_W);
            end
            DIV_STEP: begin
                div_dividend = {ts_eff, {(2*FRAC_BITS){1'b0}}};
                div_divisor  = r_wh;
                div_iters    = DIV_CNT_W'(DIV_W);
            end
            DIV_COL: begin
                div_dividend = {r_tex_column, {(DIV_W-TEXCOL_W){1'b0}}};
                div_divisor  = WH_W'(ts_eff);
                div_iters    = DIV_CNT_W'(TEXCOL_W);
            end
            default: begin
                div_dividend = '0;
                div_divisor  = WH_W'(ts_eff);
                div_iters    = '0;
            end
        endcase
    end

    tws_div #(
        .DVD_W (DIV_W),
        .DVS_W (WH_W),
        .CNT_W (DIV_CNT_W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (i_cmd.div_go),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .i_iters     (div_iters),
        .o_quotient  (div_quo),
        .o_remainder (div_rem),
        .o_done      (div_done)
    );

    // Step saturates to 32 bits
    always_comb begin
        quo_ext  = (DIV_W + WH_W)'(div_quo);
        step_sat = (|quo_ext[DIV_W+WH_W-1:WH_W]) ? {POS_W{1'b1}} : quo_ext[POS_W-1:0];
    end

    // Start offset: (row - centre) * 2^(FRAC_BITS+1) + wall height
    always_comb begin
        row_diff = $signed({1'b0, r_cur_row}) - $signed({2'b0, r_screen_h[ROW_W-1:1]});
        off2     = (OFF_W'(row_diff) <<< (FRAC_BITS + 1))
                   + $signed({{(OFF_W-WH_W){1'b0}}, r_wh});
        off_pos  = !off2[OFF_W-1] && (off2 != '0);
    end

    tws_mul #(
        .A_W (MUL_A_W),
        .B_W (WH_W)
    ) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (i_cmd.mul_go),
        .i_a       (off2[MUL_A_W-1:0]),
        .i_b       (r_step),
        .o_product (mul_prod),
        .o_done    (mul_done)
    );

    // Clamp start position to (size-1) << FRAC_BITS and to 32 bits
    always_comb begin
        pos_raw   = mul_prod[PROD_W-1:FRAC_BITS+1];
        max_pos   = PR_W'(ts_m1) << FRAC_BITS;
        pos_lim   = (max_pos > PR_W'({POS_W{1'b1}})) ? PR_W'({POS_W{1'b1}}) : max_pos;
        pos_clamp = (pos_raw > pos_lim) ? pos_lim : pos_raw;
    end

    // Pixel: texel row saturates at size-1, position advance saturates
    always_comb begin
        row_int    = r_pos >> FRAC_BITS;
        row_sat    = (row_int > POS_W'(ts_m1)) ? ts_m1[TEXCOL_W-1:0]
                                               : row_int[TEXCOL_W-1:0];
        texel_full = row_sat * ts_eff + (TS_W + TEXCOL_W)'(r_col_mod);
        pos_sum    = {1'b0, r_pos} + {1'b0, r_step};
        pos_next   = pos_sum[POS_W] ? {POS_W{1'b1}} : pos_sum[POS_W-1:0];
        row_next   = r_cur_row + ROW_W'(1);
    end

    // Column state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_column  <= '0;
            r_cur_texture <= '0;
            r_tex_column  <= '0;
            r_col_mod     <= '0;
            r_step        <= '0;
            r_pos         <= '0;
            r_cur_row     <= '0;
            r_end_row     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.latch_start) begin
                r_cur_column  <= i_in_data.column;
                r_cur_row     <= i_in_data.span_start;
                r_end_row     <= i_in_data.span_end;
                r_cur_texture <= face;
            end
            if (i_cmd.cap_hit) begin
                r_tex_column <= div_rem[TEXCOL_W-1:0];
                r_col_mod    <= div_rem[TEXCOL_W-1:0];
            end
            if (i_cmd.cap_col) begin
                r_col_mod <= div_rem[TEXCOL_W-1:0];
            end
            if (i_cmd.cap_step) begin
                r_step <= step_sat;
            end else if (i_cmd.step_ones) begin
                r_step <= {POS_W{1'b1}};
            end
            if (i_cmd.clear_pos) begin
                r_pos <= '0;
            end else if (i_cmd.cap_pos) begin
                r_pos <= pos_clamp[POS_W-1:0];
            end else if (i_cmd.emit_pixel) begin
                r_pos     <= pos_next;
                r_cur_row <= row_next;
            end
            if (i_cmd.emit_pixel) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_start) begin
            r_wh <= i_in_data.wall_height;
        end
        if (i_cmd.emit_pixel) begin
            r_out.pixel_column   <= r_cur_column;
            r_out.pixel_row      <= r_cur_row;
            r_out.texture_select <= r_cur_texture;
            r_out.texel_index    <= texel_full[TEXEL_W-1:0];
            r_out.last           <= (row_next == r_end_row);
        end
    end

    assign o_out_data  = r_out;
    assign o_out_valid = r_out_valid;

    // Status to controller
    always_comb begin
        o_status.in_pixel   = (i_in_data.command == CMD_PIXEL);
        o_status.rows_left  = (r_cur_row < r_end_row);
        o_status.out_free   = !r_out_valid || i_out_ready;
        o_status.wh_zero    = (r_wh == '0);
        o_status.pos_zero   = !off_pos || (r_step == '0);
        o_status.div_done   = div_done;
        o_status.mul_done   = mul_done;
        o_status.ts_written = apb_wr && (paddr[2] == REG_TEX_SIZE);
    end

endmodule

`default_nettype wire

// File: hdl/tws_ctrl.sv
`default_nettype none

module tws_ctrl import tws_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HIT,
        S_STEP,
        S_POS_CHK,
        S_MUL,
        S_COL
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_col_pending;
    logic   n_col_pending;

    // Ready only when idle, no column refresh owed and the output slot frees up
    assign o_in_ready = (r_state == S_IDLE) && !r_col_pending && i_status.out_free;

    // Next state and datapath commands
    always_comb begin
        n_state       = r_state;
        n_col_pending = r_col_pending || i_status.ts_written;
        o_cmd         = '0;
        case (r_state)
            S_IDLE: begin
                if (r_col_pending) begin
                    // texture size changed: refresh column modulo
                    o_cmd.div_go  = 1'b1;
                    o_cmd.div_op  = DIV_COL;
                    n_col_pending = i_status.ts_written;
                    n_state       = S_COL;
                end else if (i_in_valid && o_in_ready) begin
                    if (i_status.in_pixel) begin
                        o_cmd.emit_pixel = i_status.rows_left;
                    end else begin
                        o_cmd.latch_start = 1'b1;
                        o_cmd.div_go      = 1'b1;
                        o_cmd.div_op      = DIV_HIT;
                        n_state           = S_HIT;
                    end
                end
            end
            S_HIT: begin
                if (i_status.div_done) begin
                    o_cmd.cap_hit = 1'b1;
                    if (i_status.wh_zero) begin
                        o_cmd.step_ones = 1'b1;
                        n_state         = S_POS_CHK;
                    end else begin
                        o_cmd.div_go = 1'b1;
                        o_cmd.div_op = DIV_STEP;
                        n_state      = S_STEP;
                    end
                end
            end
            S_STEP: begin
                if (i_status.div_done) begin
                    o_cmd.cap_step = 1'b1;
                    n_state        = S_POS_CHK;
                end
            end
            S_POS_CHK: begin
                if (i_status.pos_zero) begin
                    o_cmd.clear_pos = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.mul_go = 1'b1;
                    n_state      = S_MUL;
                end
            end
            S_MUL: begin
                if (i_status.mul_done) begin
                    o_cmd.cap_pos = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_COL: begin
                if (i_status.div_done) begin
                    o_cmd.cap_col = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_col_pending <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_col_pending <= n_col_pending;
        end
    end

endmodule

`default_nettype wire

// File: hdl/textured_wall_column_sampler.sv
// Textured wall column sampler. A start beat (command 0) latches a wall slice
// and keeps the block busy while a bit-serial divider forms the texture column
// and the texture step and a shift-add multiplier forms the start position;
// a start produces no output beat. Pixel beats (command 1) are taken one per
// cycle while the output is not held by back-pressure, each giving one output
// beat from a single output register while rows of the slice remain; past the
// end of the span they are taken and dropped. A write to tex_size (APB offset
// 0x0) makes the divider refresh the texture column against the new size,
// during which no beat is taken; screen_height sits at offset 0x4.
`default_nettype none

module textured_wall_column_sampler import tws_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tws_stream_if.sink        i_cmd,
    tws_stream_if.source      o_pix,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // Sequencer
    tws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (i_cmd.ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    // Arithmetic, column state, registers and output stage
    tws_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_cmd.data),
        .o_out_data  (o_pix.data),
        .o_out_valid (o_pix.valid),
        .i_out_ready (o_pix.ready),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status)
    );

endmodule

`default_nettype wire
